// ----- sv/circular_qam_nearest_point_assert.svh -----
// Assertion macros shared by the slicer modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CIRCULAR_QAM_NEAREST_POINT_ASSERT_SVH
`define CIRCULAR_QAM_NEAREST_POINT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CQNP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CQNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cqnp_pkg.sv -----
`default_nettype none

package cqnp_pkg;

    localparam int IDX_W    = 4;
    localparam int NUM_W    = 5;
    localparam int COORD_W  = 16;
    localparam int DIST_W   = 33;
    localparam int SQ_W     = 32;
    localparam int TABLE_FRAC = 28;

    typedef struct packed {
        logic signed [COORD_W-1:0] received_i;
        logic signed [COORD_W-1:0] received_q;
    } cqnp_sample_t;

    typedef struct packed {
        logic [IDX_W-1:0]          symbol_index;
        logic signed [COORD_W-1:0] point_i;
        logic signed [COORD_W-1:0] point_q;
        logic [DIST_W-1:0]         distance_squared;
    } cqnp_result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] i;
        logic signed [COORD_W-1:0] q;
    } cqnp_coord_t;

    // One sample travelling down the row of cells, with the best match so far.
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic [NUM_W-1:0]          n;
        logic [DIST_W-1:0]         best_d;
        logic [IDX_W-1:0]          best_idx;
        logic signed [COORD_W-1:0] best_i;
        logic signed [COORD_W-1:0] best_q;
    } cqnp_token_t;

    // Ring radii in Q.28, on an axis and times sqrt(2)/2 on a diagonal.
    localparam logic [31:0] AXIS_MAG [4] = '{32'd268435456, 32'd569351602,
                                             32'd805306368, 32'd948919337};
    localparam logic [31:0] DIAG_MAG [4] = '{32'd189812531, 32'd402592379,
                                             32'd569437594, 32'd670987298};
    localparam logic [1:0] RING_OF [16] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1,
                                            2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3};
    localparam logic [2:0] ANGLE_OF [16] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4,
                                             3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4};

    // Rounds a Q.28 magnitude half up to frac bits and saturates it.
    function automatic logic signed [COORD_W-1:0] mag_to_coord(
        input logic [31:0] mag, input int frac, input logic pos, input logic neg);
        logic [31:0] r;
        int          rs;
        begin
            rs = TABLE_FRAC - frac;
            r  = (mag + (32'd1 << (rs - 1))) >> rs;
            if (r > 32'd32767)
            begin
                r = 32'd32767;
            end
            if (pos)
            begin
                mag_to_coord = r[COORD_W-1:0];
            end
            else if (neg)
            begin
                mag_to_coord = -r[COORD_W-1:0];
            end
            else
            begin
                mag_to_coord = '0;
            end
        end
    endfunction

    // Coordinates of constellation point k; angles are multiples of 45 degrees.
    function automatic cqnp_coord_t point_coord(input int k, input int frac);
        logic [1:0]  ring;
        logic [2:0]  ang;
        logic [31:0] mag;
        cqnp_coord_t c;
        begin
            ring = RING_OF[k % 16];
            ang  = ANGLE_OF[k % 16];
            mag  = ang[0] ? DIAG_MAG[ring] : AXIS_MAG[ring];
            c.i  = mag_to_coord(mag, frac,
                                (ang == 3'd0) || (ang == 3'd1) || (ang == 3'd7),
                                (ang == 3'd3) || (ang == 3'd4) || (ang == 3'd5));
            c.q  = mag_to_coord(mag, frac,
                                (ang == 3'd1) || (ang == 3'd2) || (ang == 3'd3),
                                (ang == 3'd5) || (ang == 3'd6) || (ang == 3'd7));
            point_coord = c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/cqnp_cell.sv -----
`default_nettype none

`include "circular_qam_nearest_point_assert.svh"

module cqnp_cell #(
    parameter int INDEX     = 0,
    parameter int FRAC_BITS = 12
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cqnp_pkg::cqnp_token_t tok_in,
    output cqnp_pkg::cqnp_token_t      tok_out
);
    import cqnp_pkg::*;

    localparam cqnp_coord_t      POINT = point_coord(INDEX, FRAC_BITS);
    localparam logic [NUM_W-1:0] MY_NUM = NUM_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam bit               FIRST  = (INDEX == 0);

    // Stage A: squared differences against this cell's point.
    cqnp_token_t       a_tok_reg;
    logic              a_valid_reg;
    logic [SQ_W-1:0]   sq_i_reg;
    logic [SQ_W-1:0]   sq_q_reg;
    logic [SQ_W-1:0]   sq_i_next;
    logic [SQ_W-1:0]   sq_q_next;
    logic signed [COORD_W:0]     diff_i;
    logic signed [COORD_W:0]     diff_q;
    logic signed [2*COORD_W+1:0] prod_i;
    logic signed [2*COORD_W+1:0] prod_q;

    // Stage B: running minimum.
    cqnp_token_t       b_tok_reg;
    cqnp_token_t       b_tok_next;
    logic              b_valid_reg;
    logic [DIST_W-1:0] cand_d;
    logic              take;

    always_comb
    begin
        diff_i    = {tok_in.rx[COORD_W-1], tok_in.rx} - {POINT.i[COORD_W-1], POINT.i};
        diff_q    = {tok_in.ry[COORD_W-1], tok_in.ry} - {POINT.q[COORD_W-1], POINT.q};
        prod_i    = diff_i * diff_i;
        prod_q    = diff_q * diff_q;
        sq_i_next = prod_i[SQ_W-1:0];
        sq_q_next = prod_q[SQ_W-1:0];
    end

    always_comb
    begin
        cand_d = {1'b0, sq_i_reg} + {1'b0, sq_q_reg};
        // Strict less-than keeps the lower index on a tie.
        take = FIRST || ((MY_NUM < a_tok_reg.n) && (cand_d < a_tok_reg.best_d));
        b_tok_next = a_tok_reg;
        if (take)
        begin
            b_tok_next.best_d   = cand_d;
            b_tok_next.best_idx = MY_IDX;
            b_tok_next.best_i   = POINT.i;
            b_tok_next.best_q   = POINT.q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= tok_in.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tok_reg <= tok_in;
        sq_i_reg  <= sq_i_next;
        sq_q_reg  <= sq_q_next;
        b_tok_reg <= b_tok_next;
    end

    always_comb
    begin
        tok_out       = b_tok_reg;
        tok_out.valid = b_valid_reg;
    end

    if (!FIRST)
    begin : g_chk
        `CQNP_ASSERT_SAME(a_best_not_worse, tok_out.valid, tok_out.best_d <= $past(tok_in.best_d, 2), "best distance grew inside a cell")
        `CQNP_ASSERT_SAME(a_index_in_range, tok_out.valid && (tok_out.best_idx == MY_IDX), MY_NUM < tok_out.n, "cell outside the active point count won")
    end

endmodule

`default_nettype wire

// ----- sv/circular_qam_nearest_point.sv -----
// Minimum-distance slicer for a 16-point four-ring star QAM constellation.
// Throughput: one sample per cycle; each cell of the row adds two pipeline stages.
// busy stays low, so start is always taken; done is high for one cycle per result
// and the receiver cannot stall it.
// Reset clears all pipeline valid bits and sets num_points to 16.
`default_nettype none

`include "circular_qam_nearest_point_assert.svh"

module circular_qam_nearest_point #(
    parameter int MAX_POINTS      = 16,
    parameter int COORD_FRAC_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire cqnp_pkg::cqnp_sample_t sample,
    output logic                       done,
    output cqnp_pkg::cqnp_result_t     result,
    input  wire logic                  cfg_we,
    input  wire logic [4:0]            cfg_data
);
    import cqnp_pkg::*;

    localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_POINTS);
    localparam int               LAT   = 2 * MAX_POINTS;

    logic [NUM_W-1:0] num_points_reg;
    logic [NUM_W-1:0] n_eff;
    cqnp_token_t      tok [MAX_POINTS+1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NUM_W'(16);
        end
        else if (cfg_we)
        begin
            num_points_reg <= cfg_data;
        end
    end

    always_comb
    begin
        priority if (num_points_reg == '0)
        begin
            n_eff = NUM_W'(1);
        end
        else if (num_points_reg > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = num_points_reg;
        end
    end

    always_comb
    begin
        tok[0]          = '0;
        tok[0].valid    = start && !busy;
        tok[0].rx       = sample.received_i;
        tok[0].ry       = sample.received_q;
        tok[0].n        = n_eff;
    end

    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cell
        cqnp_cell #(
            .INDEX     (k),
            .FRAC_BITS (COORD_FRAC_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    always_comb
    begin
        done                    = tok[MAX_POINTS].valid;
        result.symbol_index     = tok[MAX_POINTS].best_idx;
        result.point_i          = tok[MAX_POINTS].best_i;
        result.point_q          = tok[MAX_POINTS].best_q;
        result.distance_squared = tok[MAX_POINTS].best_d;
    end

    `CQNP_ASSERT_SAME(a_done_follows_start, done, $past(start, LAT), "result without a matching start transfer")
    `CQNP_ASSERT_SAME(a_index_below_count, done, {1'b0, result.symbol_index} < n_eff, "symbol index beyond active point count")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cqnp_pkg::*;

    localparam int POINTS     = 16;
    localparam int FRAC_BITS  = 12;
    localparam int Q28_SHIFT  = 28 - FRAC_BITS;
    localparam int PIPE_DEPTH = 2 * POINTS;
    localparam int RANDOM_ITEMS = 650;
    localparam int NO_GAP_FIRST = 250;
    localparam int NO_GAP_LAST  = 400;

    // Ring radii in Q.28, on an axis and scaled by sqrt(2)/2 on a diagonal.
    localparam int unsigned AXIS_RADIUS [4] = '{32'd268435456, 32'd569351602,
                                                32'd805306368, 32'd948919337};
    localparam int unsigned DIAG_RADIUS [4] = '{32'd189812531, 32'd402592379,
                                                32'd569437594, 32'd670987298};
    localparam int POINT_RING  [16] = '{0, 1, 1, 0, 1, 0, 0, 1, 2, 3, 3, 2, 3, 2, 2, 3};
    localparam int POINT_ANGLE [16] = '{1, 0, 2, 3, 6, 7, 5, 4, 1, 0, 2, 3, 6, 7, 5, 4};
    localparam int COS_SIGN [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    localparam int SIN_SIGN [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    class nearest_point_board;
        logic signed [COORD_W-1:0] point_re [POINTS];
        logic signed [COORD_W-1:0] point_im [POINTS];
        logic [NUM_W-1:0]          num_points;
        cqnp_result_t              expected_decisions [$];
        int                        errors;

        function new();
            int ang;
            int unsigned mag;
            for (int k = 0; k < POINTS; k++)
            begin
                ang = POINT_ANGLE[k % 16];
                mag = (ang % 2 == 1) ? DIAG_RADIUS[POINT_RING[k % 16]]
                                     : AXIS_RADIUS[POINT_RING[k % 16]];
                point_re[k] = to_fixed(mag, COS_SIGN[ang]);
                point_im[k] = to_fixed(mag, SIN_SIGN[ang]);
            end
            num_points = 5'd16;
            errors = 0;
        endfunction

        // Rounds half up in magnitude, saturates, then applies the sign.
        function logic signed [COORD_W-1:0] to_fixed(int unsigned mag, int sgn);
            longint unsigned r;
            r = (longint'(mag) + (64'd1 << (Q28_SHIFT - 1))) >> Q28_SHIFT;
            if (r > 32767)
            begin
                r = 32767;
            end
            if (sgn > 0)
            begin
                return r[COORD_W-1:0];
            end
            else if (sgn < 0)
            begin
                return -r[COORD_W-1:0];
            end
            return '0;
        endfunction

        function void set_num_points(logic [NUM_W-1:0] v);
            num_points = v;
        endfunction

        function int pending();
            return expected_decisions.size();
        endfunction

        function void add_sample(cqnp_sample_t s);
            int n;
            int best;
            longint dx;
            longint dy;
            longint unsigned d;
            longint unsigned best_d;
            cqnp_result_t r;
            n = int'(num_points);
            if (n < 1)
            begin
                n = 1;
            end
            if (n > POINTS)
            begin
                n = POINTS;
            end
            best = 0;
            best_d = 0;
            for (int k = 0; k < n; k++)
            begin
                dx = longint'(s.received_i) - longint'(point_re[k]);
                dy = longint'(s.received_q) - longint'(point_im[k]);
                d = dx * dx + dy * dy;
                // Strict comparison keeps the lowest index on a tie.
                if (k == 0 || d < best_d)
                begin
                    best_d = d;
                    best = k;
                end
            end
            r.symbol_index     = best[IDX_W-1:0];
            r.point_i          = point_re[best];
            r.point_q          = point_im[best];
            r.distance_squared = best_d[DIST_W-1:0];
            expected_decisions.push_back(r);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(cqnp_result_t got);
            cqnp_result_t want;
            if (expected_decisions.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual index %0d",
                         $time, got.symbol_index);
                errors++;
                return;
            end
            want = expected_decisions.pop_front();
            if (got.symbol_index !== want.symbol_index)
            begin
                report("symbol_index", want.symbol_index, got.symbol_index);
            end
            if (got.point_i !== want.point_i)
            begin
                report("point_i", 16'(want.point_i), 16'(got.point_i));
            end
            if (got.point_q !== want.point_q)
            begin
                report("point_q", 16'(want.point_q), 16'(got.point_q));
            end
            if (got.distance_squared !== want.distance_squared)
            begin
                report("distance_squared", want.distance_squared, got.distance_squared);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cqnp_sample_t     sample;
    logic             done;
    cqnp_result_t     result;
    logic             cfg_we;
    logic [NUM_W-1:0] cfg_data;

    nearest_point_board board = new();
    bit idle_ok;

    circular_qam_nearest_point #(
        .MAX_POINTS      (POINTS),
        .COORD_FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .sample   (sample),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            board.check_result(result);
        end
    end

    function automatic cqnp_sample_t make_sample(int i, int q);
        cqnp_sample_t s;
        s.received_i = i[COORD_W-1:0];
        s.received_q = q[COORD_W-1:0];
        return s;
    endfunction

    // Mostly noisy constellation points and midpoints between two points,
    // with full-range values and corners mixed in.
    function automatic cqnp_sample_t pick_sample();
        int mode;
        int a;
        int b;
        int spread;
        mode = $urandom_range(99);
        a = $urandom_range(POINTS - 1);
        b = $urandom_range(POINTS - 1);
        spread = 1 << $urandom_range(12, 2);
        if (mode < 55)
        begin
            return make_sample(int'(board.point_re[a]) + $urandom_range(2 * spread) - spread,
                               int'(board.point_im[a]) + $urandom_range(2 * spread) - spread);
        end
        else if (mode < 75)
        begin
            return make_sample((int'(board.point_re[a]) + int'(board.point_re[b])) >>> 1,
                               (int'(board.point_im[a]) + int'(board.point_im[b])) >>> 1);
        end
        else if (mode < 95)
        begin
            return make_sample($urandom_range(65535), $urandom_range(65535));
        end
        return make_sample($urandom_range(1) ? 32767 : -32768,
                           $urandom_range(1) ? 32767 : -32768);
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic drive_sample(input cqnp_sample_t s);
        if (idle_ok && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1))
                @(posedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        board.add_sample(s);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
        @(posedge clk);
    endtask

    task automatic write_num_points(input logic [NUM_W-1:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_num_points(v);
    endtask

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [NUM_W-1:0] plan [9];
        int sent;
        int phase;
        int len;
        int waited;
        plan = '{5'd1, 5'd2, 5'd17, 5'd16, 5'd8, 5'd0, 5'd31, 5'd15, 5'd4};
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        sample   = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        idle_ok  = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the four inner points tie at the origin, then the corners
        // of the sample range, then every point hit exactly.
        drive_sample(make_sample(0, 0));
        drive_sample(make_sample(32767, 32767));
        drive_sample(make_sample(-32768, -32768));
        drive_sample(make_sample(-32768, 32767));
        drive_sample(make_sample(32767, -32768));
        for (int k = 0; k < POINTS; k++)
        begin
            drive_sample(make_sample(board.point_re[k], board.point_im[k]));
        end
        // Zero points acts as one point; too many acts as all of them.
        write_num_points(5'd0);
        drive_sample(make_sample(-14479, 0));
        drive_sample(make_sample(32767, -32768));
        write_num_points(5'd31);
        drive_sample(make_sample(-14479, 0));
        drive_sample(make_sample(0, -8688));

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_num_points(phase < 9 ? plan[phase] : NUM_W'($urandom_range(31)));
            len = $urandom_range(60, 20);
            repeat (len)
            begin
                idle_ok = !(sent >= NO_GAP_FIRST && sent < NO_GAP_LAST);
                drive_sample(pick_sample());
                sent++;
            end
            phase++;
        end

        start <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 20 * PIPE_DEPTH)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0t: %0d results missing, expected 0 outstanding, actual %0d",
                     $time, board.pending(), board.pending());
            board.errors++;
        end
        if (board.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- circular_qam_nearest_point.f -----
+incdir+sv
sv/cqnp_pkg.sv
sv/cqnp_cell.sv
sv/circular_qam_nearest_point.sv
tb/sv/tb_top.sv
